@@ design/multi_source_time_matcher_defines.svh @@
// Assertion macros for the multi-source time matcher.
// No dependencies; included by the top level only.
`ifndef MULTI_SOURCE_TIME_MATCHER_DEFINES_SVH
`define MULTI_SOURCE_TIME_MATCHER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define MSTM_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define MSTM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mstm_pkg.sv @@
// Shared types and constants for the multi-source time matcher.
// No dependencies; used by every module of the block except mstm_ram.
package mstm_pkg;

  // Input item fields.
  typedef struct packed {
    logic [2:0]  source_id;
    logic [47:0] beam_time;
    logic [31:0] dwell_time;
    logic [15:0] beam_tag;
    logic [31:0] wall_seconds;
  } in_item_t;

  // Result item fields.
  typedef struct packed {
    logic        event_kind;
    logic [2:0]  member_source;
    logic [15:0] member_tag;
    logic [31:0] matches_so_far;
    logic        last_of_set;
  } out_item_t;

  // One store entry.
  typedef struct packed {
    logic [47:0] etime;
    logic [2:0]  esrc;
    logic [15:0] etag;
  } entry_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ENABLED_MASK  = 2'd0;
  localparam logic [1:0] CFG_SOURCE_COUNT  = 2'd1;
  localparam logic [1:0] CFG_STALE_TIMEOUT = 2'd2;

  // Reset values and limits.
  localparam logic [7:0]  ENABLED_RESET = 8'd255;
  localparam logic [2:0]  SRCCNT_RESET  = 3'd2;
  localparam logic [15:0] TIMEOUT_RESET = 16'd60;
  localparam logic [31:0] TOL_RESET     = 32'd1000000;
  localparam logic [31:0] BEST_INIT     = 32'd999000000;

  // Event kinds.
  localparam logic KIND_MEMBER = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Datapath commands.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_SH_EV,
    OP_INS,
    OP_DIFF,
    OP_DN_CMP,
    OP_UP_INIT,
    OP_UP_CMP,
    OP_DECIDE,
    OP_EMIT,
    OP_SKIP,
    OP_FLUSH_OUT,
    OP_CP_EV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Datapath status toward the controller.
  typedef struct packed {
    logic src_bad;
    logic count_zero;
    logic sh_stop;
    logic sh_drop;
    logic idx_zero;
    logic p_zero;
    logic d_out;
    logic up_end;
    logic up_last;
    logic fail;
    logic flush;
    logic out_free;
    logic em_has;
    logic em_last;
    logic cp_last;
  } dp_status_t;

endpackage

@@ design/mstm_ram.sv @@
// Generic simple dual-port RAM with registered read.
// No dependencies.
module mstm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/mstm_datapath.sv @@
// Datapath: item and configuration registers, sorted store, match scan and result register.
// Depends on mstm_pkg and mstm_ram.
module mstm_datapath #(
  parameter int STORE_DEPTH = 1024,
  parameter int SRC_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  mstm_pkg::dp_cmd_t   cmd,
  output mstm_pkg::dp_status_t status,
  input  mstm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mstm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import mstm_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int SW = $clog2(SRC_SLOTS);

  // Configuration registers.
  logic [7:0]  enabled_mask;
  logic [2:0]  source_count;
  logic [15:0] stale_timeout;

  // Persistent state.
  logic [CW-1:0] count;
  logic [31:0]   tol;
  logic [31:0]   lms;
  logic          known;
  logic [31:0]   counter;

  // Per-item working registers.
  in_item_t      itm;
  logic [AW-1:0] idx;
  logic [AW-1:0] p;
  logic          full;
  logic [CW-1:0] brk;
  logic [CW-1:0] w;
  logic [SW-1:0] ei;
  logic [SRC_SLOTS-1:0] has;
  logic [31:0]   best [SRC_SLOTS];
  logic [AW-1:0] pick [SRC_SLOTS];
  logic [15:0]   ptag [SRC_SLOTS];
  logic [47:0]   d;
  logic [2:0]    dsrc;
  logic [15:0]   dtag;
  logic [AW-1:0] didx;

  // Store memory.
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  entry_t        rdata;

  mstm_ram #(.WIDTH($bits(entry_t)), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  // Effective source count and derived item values.
  logic [2:0]    nsrc;
  logic [SW-1:0] isrc;
  logic [SW-1:0] ds;
  logic [31:0]   d32;
  logic [CW-1:0] cnt_ins;
  logic          last_slot;
  logic          upd;
  logic          picked;
  logic          more;
  logic          fail;
  logic [31:0]   eff;
  logic          flush;
  logic          out_load;

  always_comb begin
    nsrc = (source_count > 3'(SRC_SLOTS - 1)) ? 3'(SRC_SLOTS - 1) : source_count;
    isrc = itm.source_id[SW-1:0];
    ds   = dsrc[SW-1:0];
    d32  = d[31:0];
    cnt_ins   = full ? CW'(STORE_DEPTH) : count + CW'(1);
    last_slot = (idx == AW'(STORE_DEPTH - 1));
  end

  // Candidate test: on a tie the entry with the lower index wins.
  always_comb begin
    upd = 1'b0;
    if (!status.d_out && (dsrc < nsrc) && (dsrc != itm.source_id)) begin
      if (cmd.op == OP_DN_CMP) begin
        upd = has[ds] ? (d32 <= best[ds]) : (d32 < BEST_INIT);
      end else begin
        upd = d32 < best[ds];
      end
    end
  end

  // Per-source reductions: chosen entry, later members, missing sources.
  always_comb begin
    picked = 1'b0;
    more   = 1'b0;
    fail   = 1'b0;
    for (int j = 0; j < SRC_SLOTS; j++) begin
      if (3'(j) < nsrc) begin
        if (has[j] && (pick[j] == idx)) picked = 1'b1;
        if (has[j] && (SW'(j) > ei)) more = 1'b1;
        if (enabled_mask[j] && !has[j]) fail = 1'b1;
      end
    end
    eff   = known ? lms : itm.wall_seconds;
    flush = fail && (itm.wall_seconds >= eff) &&
            ((itm.wall_seconds - eff) > {16'd0, stale_timeout});
  end

  // Status toward the controller.
  always_comb begin
    status.src_bad    = itm.source_id >= nsrc;
    status.count_zero = count == '0;
    status.sh_stop    = itm.beam_time < rdata.etime;
    status.sh_drop    = status.sh_stop && full && last_slot;
    status.idx_zero   = idx == '0;
    status.p_zero     = p == '0;
    status.d_out      = d > {16'd0, tol};
    status.up_end     = (CW'(p) + CW'(1)) >= count;
    status.up_last    = (CW'(idx) + CW'(1)) >= count;
    status.fail       = fail;
    status.flush      = flush;
    status.out_free   = !out_valid || !out_stall;
    status.em_has     = has[ei] && (3'(ei) < nsrc);
    status.em_last    = !more;
    status.cp_last    = ((CW'(idx) + CW'(1)) >= count) || (CW'(idx) == brk);
  end

  // Store write port.
  always_comb begin
    we    = 1'b0;
    waddr = idx + AW'(1);
    wdata = rdata;
    unique case (cmd.op)
      OP_SH_EV: begin
        we = !status.sh_stop && !(full && last_slot);
      end
      OP_INS: begin
        we    = 1'b1;
        waddr = p;
        wdata = '{etime: itm.beam_time, esrc: itm.source_id, etag: itm.beam_tag};
      end
      OP_CP_EV: begin
        we    = !picked;
        waddr = w[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask  <= ENABLED_RESET;
      source_count  <= SRCCNT_RESET;
      stale_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      priority case (cfg_index)
        CFG_ENABLED_MASK:  enabled_mask  <= cfg_data[7:0];
        CFG_SOURCE_COUNT:  source_count  <= cfg_data[2:0];
        CFG_STALE_TIMEOUT: stale_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Persistent state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      tol     <= TOL_RESET;
      lms     <= '0;
      known   <= 1'b0;
      counter <= '0;
    end else begin
      if (cmd.op == OP_INS) begin
        count <= cnt_ins;
        if (itm.source_id == 3'd0) tol <= {1'b0, itm.dwell_time[31:1]};
      end
      if (cmd.op == OP_DECIDE) begin
        if (fail) begin
          if (!known) begin
            lms   <= itm.wall_seconds;
            known <= 1'b1;
          end
          if (flush) begin
            count <= '0;
            lms   <= itm.wall_seconds;
          end
        end else begin
          lms     <= itm.wall_seconds;
          known   <= 1'b1;
          counter <= counter + 32'd1;
        end
      end
      if ((cmd.op == OP_CP_EV) && status.cp_last) begin
        count <= picked ? w : w + CW'(1);
      end
    end
  end

  // Working registers of the item being processed.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: itm <= in_data;
      OP_START: begin
        p    <= '0;
        idx  <= AW'(count - CW'(1));
        full <= count == CW'(STORE_DEPTH);
      end
      OP_SH_EV: begin
        if (status.sh_stop) p <= idx + AW'(1);
        else if (idx != '0) idx <= idx - AW'(1);
      end
      OP_INS: begin
        for (int j = 0; j < SRC_SLOTS; j++) begin
          has[j]  <= 1'b0;
          best[j] <= BEST_INIT;
        end
        has[isrc]  <= 1'b1;
        best[isrc] <= '0;
        pick[isrc] <= p;
        ptag[isrc] <= itm.beam_tag;
        brk        <= cnt_ins;
        idx        <= p - AW'(1);
      end
      OP_DIFF: begin
        d    <= (rdata.etime >= itm.beam_time) ? rdata.etime - itm.beam_time
                                               : itm.beam_time - rdata.etime;
        dsrc <= rdata.esrc;
        dtag <= rdata.etag;
        didx <= idx;
      end
      OP_DN_CMP, OP_UP_CMP: begin
        if (upd) begin
          has[ds]  <= 1'b1;
          best[ds] <= d32;
          pick[ds] <= didx;
          ptag[ds] <= dtag;
        end
        if (cmd.op == OP_DN_CMP) begin
          idx <= idx - AW'(1);
        end else begin
          if (status.d_out) brk <= CW'(idx);
          idx <= idx + AW'(1);
        end
      end
      OP_UP_INIT: idx <= p + AW'(1);
      OP_DECIDE: begin
        idx <= '0;
        w   <= '0;
        ei  <= '0;
      end
      OP_EMIT, OP_SKIP: ei <= ei + SW'(1);
      OP_CP_EV: begin
        if (!picked) w <= w + CW'(1);
        idx <= idx + AW'(1);
      end
      default: ;
    endcase
  end

  // Result register.
  assign out_load = (cmd.op == OP_EMIT) || (cmd.op == OP_FLUSH_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_data.event_kind     <= KIND_MEMBER;
      out_data.member_source  <= 3'(ei);
      out_data.member_tag     <= ptag[ei];
      out_data.matches_so_far <= counter;
      out_data.last_of_set    <= !more;
    end else if (cmd.op == OP_FLUSH_OUT) begin
      out_data.event_kind     <= KIND_FLUSH;
      out_data.member_source  <= '0;
      out_data.member_tag     <= '0;
      out_data.matches_so_far <= counter;
      out_data.last_of_set    <= 1'b1;
    end
  end
endmodule

@@ design/mstm_ctrl.sv @@
// Controller: sequences insertion, window search, decision, flush, emission and compaction.
// Depends on mstm_pkg.
module mstm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output mstm_pkg::dp_cmd_t    cmd,
  input  mstm_pkg::dp_status_t status
);
  import mstm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_SH_RD, S_SH_EV, S_INS, S_DN_RD, S_DN_DIF, S_DN_CMP,
    S_UP_INIT, S_UP_RD, S_UP_DIF, S_UP_CMP, S_DECIDE, S_FLUSH, S_EMIT,
    S_CP_RD, S_CP_EV
  } state_t;

  state_t state, state_next;

  assign in_stall = state != S_IDLE;

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.op = OP_START;
        if (status.src_bad) state_next = S_IDLE;
        else if (status.count_zero) state_next = S_INS;
        else state_next = S_SH_RD;
      end
      S_SH_RD: state_next = S_SH_EV;
      S_SH_EV: begin
        cmd.op = OP_SH_EV;
        if (status.sh_drop) state_next = S_IDLE;
        else if (status.sh_stop || status.idx_zero) state_next = S_INS;
        else state_next = S_SH_RD;
      end
      S_INS: begin
        cmd.op     = OP_INS;
        state_next = status.p_zero ? S_UP_INIT : S_DN_RD;
      end
      S_DN_RD: state_next = S_DN_DIF;
      S_DN_DIF: begin
        cmd.op     = OP_DIFF;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.op     = OP_DN_CMP;
        state_next = (status.d_out || status.idx_zero) ? S_UP_INIT : S_DN_RD;
      end
      S_UP_INIT: begin
        cmd.op     = OP_UP_INIT;
        state_next = status.up_end ? S_DECIDE : S_UP_RD;
      end
      S_UP_RD: state_next = S_UP_DIF;
      S_UP_DIF: begin
        cmd.op     = OP_DIFF;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.op     = OP_UP_CMP;
        state_next = (status.d_out || status.up_last) ? S_DECIDE : S_UP_RD;
      end
      S_DECIDE: begin
        cmd.op = OP_DECIDE;
        if (status.fail) state_next = status.flush ? S_FLUSH : S_IDLE;
        else state_next = S_EMIT;
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.op     = OP_FLUSH_OUT;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!status.em_has) begin
          cmd.op = OP_SKIP;
        end else if (status.out_free) begin
          cmd.op = OP_EMIT;
          if (status.em_last) state_next = S_CP_RD;
        end
      end
      S_CP_RD: state_next = S_CP_EV;
      S_CP_EV: begin
        cmd.op     = OP_CP_EV;
        state_next = status.cp_last ? S_IDLE : S_CP_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

@@ design/multi_source_time_matcher.sv @@
// From acceptance back to idle the block walks the store to find the insert slot, reads
// the entries around it for the window, takes one emit step per source up to the last
// member (held by output stalls), and walks the stored entries again for compaction.
// A missed match ends after the decision step, a flush after its single result.
// One item at a time: the next is taken in the idle cycle that follows. Synchronous
// active-high reset empties the store, restores config and match state; no clearing pass. Uses mstm_*.
`include "multi_source_time_matcher_defines.svh"

module multi_source_time_matcher #(
  parameter int STORE_DEPTH = 1024,
  parameter int SRC_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mstm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mstm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import mstm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration is taken at any time.
  assign cfg_ready = 1'b1;

  mstm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  mstm_datapath #(.STORE_DEPTH(STORE_DEPTH), .SRC_SLOTS(SRC_SLOTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // An accepted item keeps the block busy in the next cycle.
  `MSTM_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall,
                    "not busy after accept")
  // A flush result is a single, empty result.
  `MSTM_ASSERT_SAME(a_flush_shape, clk, rst, out_valid && out_data.event_kind == KIND_FLUSH,
                    out_data.last_of_set && out_data.member_tag == 16'd0 &&
                    out_data.member_source == 3'd0, "bad flush result")
  // Once a non-final member is taken, the rest of the set is still pending.
  `MSTM_ASSERT_NEXT(a_set_pending, clk, rst, out_valid && !out_stall && !out_data.last_of_set,
                    in_stall, "set ended early")
endmodule

@@ verif/multi_source_time_matcher_test.sv @@
// Self-checking testbench for the multi-source time matcher.
// Depends on mstm_pkg and the multi_source_time_matcher top level.
`timescale 1ns / 1ps

module multi_source_time_matcher_test;
  import mstm_pkg::*;

  localparam int DEPTH = 64;
  localparam longint CYCLE_LIMIT = 8000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_ENABLED_MASK;
  logic [15:0] cfg_data = '0;

  multi_source_time_matcher #(.STORE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted store, registers and match state.
  logic [47:0] st_time [DEPTH];
  logic [2:0]  st_src [DEPTH];
  logic [15:0] st_tag [DEPTH];
  int unsigned st_count;
  logic [31:0] tolerance;
  logic [31:0] last_seconds;
  bit          last_known;
  logic [31:0] match_total;
  logic [7:0]  mask_reg;
  logic [2:0]  srccnt_reg;
  logic [15:0] timeout_reg;

  out_item_t expected_results[$];
  int errors = 0;
  bit hold_off = 1'b0;
  logic [31:0] wall_now = 32'd1000;
  logic [47:0] time_now;

  // Append one expected result.
  function automatic void expect_result(logic kind, logic [2:0] s, logic [15:0] tg,
                                        logic last);
    out_item_t r;
    r.event_kind = kind;
    r.member_source = s;
    r.member_tag = tg;
    r.matches_so_far = match_total;
    r.last_of_set = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Insert one item into the predicted store and work out its results.
  function automatic void predict_match(in_item_t it);
    int unsigned nsrc, p, e, brk, w, i, s, n, last_idx;
    longint unsigned d;
    longint unsigned best [8];
    int unsigned pick [8];
    bit has [8];
    bit drop;
    nsrc = (srccnt_reg > 7) ? 7 : srccnt_reg;
    if (it.source_id >= nsrc) return;
    p = 0;
    while (p < st_count && it.beam_time < st_time[p]) p++;
    if (st_count >= DEPTH) begin
      if (p >= st_count) return;
      st_count = DEPTH - 1;
    end
    for (i = st_count; i > p; i--) begin
      st_time[i] = st_time[i-1];
      st_src[i] = st_src[i-1];
      st_tag[i] = st_tag[i-1];
    end
    st_time[p] = it.beam_time;
    st_src[p] = it.source_id;
    st_tag[p] = it.beam_tag;
    st_count++;
    if (it.source_id == 0) tolerance = it.dwell_time >> 1;

    e = p;
    while (e > 0 && longint'(st_time[e-1] - it.beam_time) <= tolerance) e--;
    for (i = 0; i < 8; i++) begin
      best[i] = BEST_INIT;
      pick[i] = 0;
      has[i] = 1'b0;
    end
    best[it.source_id] = 0;
    pick[it.source_id] = p;
    has[it.source_id] = 1'b1;

    brk = st_count;
    for (i = e; i < st_count; i++) begin
      if (i == p) continue;
      d = (st_time[i] >= it.beam_time) ? st_time[i] - it.beam_time
                                       : it.beam_time - st_time[i];
      if (d > tolerance) begin
        brk = i;
        break;
      end
      s = st_src[i];
      if (s < nsrc && d < best[s]) begin
        best[s] = d;
        pick[s] = i;
        has[s] = 1'b1;
      end
    end

    // A required source is missing: possibly flush on a stale store.
    for (i = 0; i < nsrc; i++) begin
      if (mask_reg[i] && !has[i]) begin
        if (!last_known) begin
          last_seconds = it.wall_seconds;
          last_known = 1'b1;
        end
        if (it.wall_seconds >= last_seconds &&
            it.wall_seconds - last_seconds > timeout_reg) begin
          st_count = 0;
          last_seconds = it.wall_seconds;
          expect_result(KIND_FLUSH, 3'd0, 16'd0, 1'b1);
        end
        return;
      end
    end

    last_seconds = it.wall_seconds;
    last_known = 1'b1;
    match_total++;
    n = 0;
    for (i = 0; i < nsrc; i++) if (has[i]) begin
      n++;
      last_idx = i;
    end
    for (i = 0; i < nsrc; i++)
      if (has[i]) expect_result(KIND_MEMBER, i[2:0], st_tag[pick[i]], i == last_idx);

    // Remove the chosen entries and everything past the break.
    w = 0;
    for (i = 0; i < st_count; i++) begin
      drop = (brk < st_count && i > brk);
      for (s = 0; s < nsrc && !drop; s++)
        if (has[s] && pick[s] == i) drop = 1'b1;
      if (drop) continue;
      st_time[w] = st_time[i];
      st_src[w] = st_src[i];
      st_tag[w] = st_tag[i];
      w++;
    end
    st_count = w;
  endfunction

  // Offer one item after a random gap and wait until it is taken.
  task automatic send_item(logic [2:0] s, logic [47:0] t, logic [31:0] dw,
                           logic [15:0] tg, logic [31:0] wall);
    in_item_t it;
    int gap;
    it.source_id = s;
    it.beam_time = t;
    it.dwell_time = dw;
    it.beam_tag = tg;
    it.wall_seconds = wall;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (gap) @(negedge clk);
    in_data = it;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_match(it);
    @(negedge clk);
    in_valid = 1'b0;
    in_data = {3'($urandom), $urandom, 16'($urandom), 16'($urandom), $urandom, $urandom};
  endtask

  // Let the block finish its work before a register write.
  task automatic wait_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8 * st_count + 64) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    wait_idle();
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_ENABLED_MASK:  mask_reg = val[7:0];
      CFG_SOURCE_COUNT:  srccnt_reg = val[2:0];
      CFG_STALE_TIMEOUT: timeout_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One beam: the transmitter item first, then receivers near its time.
  task automatic send_beam(int unsigned nsrc, logic [31:0] tol, bit sloppy);
    int unsigned s;
    logic [47:0] t;
    time_now = time_now + 48'(tol) * 3 + $urandom_range(1, 5000);
    send_item(3'd0, time_now, {tol[30:0], 1'b0} | 32'($urandom_range(0, 1)),
              16'($urandom), wall_now);
    for (s = 1; s < nsrc; s++) begin
      if (sloppy && $urandom_range(0, 4) == 0) continue;
      t = $urandom_range(0, 1) ? time_now + $urandom_range(0, tol)
                               : time_now - $urandom_range(0, tol);
      if (sloppy && $urandom_range(0, 5) == 0) t = t + 48'(tol) + 1;
      send_item(s[2:0], t, $urandom, 16'($urandom), wall_now);
      if ($urandom_range(0, 3) == 0)
        send_item(s[2:0], t + $urandom_range(0, 3), $urandom, 16'($urandom), wall_now);
    end
    wall_now = wall_now + $urandom_range(0, 2);
  endtask

  // A random item with random fields; its wall time is mostly the current one.
  task automatic send_noise();
    send_item(3'($urandom), 48'({$urandom, $urandom}), $urandom, 16'($urandom),
              $urandom_range(0, 3) == 0 ? $urandom : wall_now);
  endtask

  // Reset values and a plain two-source match.
  task automatic test_reset_values();
    time_now = 48'd5000000;
    send_item(3'd0, time_now, 32'd200, 16'h0000, wall_now);
    send_item(3'd1, time_now + 48'd100, 32'hFFFFFFFF, 16'hFFFF, wall_now);
    send_item(3'd2, time_now, 32'd0, 16'h1234, wall_now);
    send_item(3'd1, time_now + 48'd5000, 32'd0, 16'h0F0F, wall_now);
  endtask

  // Field extremes, tie breaks, clock going back and the flush.
  task automatic test_directed();
    write_reg(CFG_SOURCE_COUNT, 16'hFFFF);
    write_reg(CFG_ENABLED_MASK, 16'h0007);
    send_item(3'd0, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 16'hAAAA, wall_now);
    send_item(3'd1, 48'hFFFFFFFFFFF0, 32'd0, 16'h5555, wall_now);
    send_item(3'd1, 48'hFFFFFFFFFFF0, 32'd0, 16'h5556, wall_now);
    send_item(3'd2, 48'hFFFFFFFFFFFF, 32'd0, 16'h0001, wall_now);
    send_item(3'd7, 48'h0, 32'd0, 16'hFFFF, 32'hFFFFFFFF);
    send_item(3'd0, 48'h0, 32'd1, 16'h0002, wall_now);
    send_item(3'd1, 48'h0, 32'd1, 16'h0003, wall_now);
    send_item(3'd2, 48'h1, 32'd1, 16'h0004, wall_now);
    write_reg(CFG_STALE_TIMEOUT, 16'd0);
    send_item(3'd1, 48'h100, 32'd0, 16'h0005, wall_now - 32'd5);
    send_item(3'd1, 48'h200, 32'd0, 16'h0006, wall_now);
    send_item(3'd1, 48'h300, 32'd0, 16'h0007, wall_now + 32'd1);
    wall_now = wall_now + 32'd2;
    write_reg(CFG_ENABLED_MASK, 16'h0000);
    send_item(3'd6, 48'h400, 32'd0, 16'h0008, wall_now);
    write_reg(CFG_SOURCE_COUNT, 16'd0);
    send_item(3'd0, 48'h500, 32'd0, 16'h0009, wall_now);
    write_reg(CFG_SOURCE_COUNT, 16'd3);
    write_reg(CFG_ENABLED_MASK, 16'hFF00);
    send_item(3'd2, 48'h600, 32'd0, 16'h000A, wall_now);
  endtask

  // Fill the store until it overflows, then flush it.
  task automatic test_full_store();
    int k;
    write_reg(CFG_SOURCE_COUNT, 16'd2);
    write_reg(CFG_ENABLED_MASK, 16'h00FF);
    write_reg(CFG_STALE_TIMEOUT, 16'hFFFF);
    for (k = 0; k < DEPTH + 3; k++)
      send_item(3'd0, 48'd900000000 - 48'(k) * 10, 32'd0, 16'(k), wall_now);
    send_item(3'd0, 48'd900000005, 32'd0, 16'hBEEF, wall_now);
    send_item(3'd0, 48'd1, 32'd7000, 16'hDEAD, wall_now);
    write_reg(CFG_STALE_TIMEOUT, 16'd3);
    wall_now = wall_now + 32'd4;
    send_item(3'd0, 48'd900000020, 32'd0, 16'hF00D, wall_now);
  endtask

  // Mostly well-formed beams under several settings, with noise between.
  task automatic test_random(int count);
    int sent;
    int unsigned nsrc;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        nsrc = $urandom_range(1, 7);
        write_reg(CFG_SOURCE_COUNT, {13'($urandom), nsrc[2:0]});
        write_reg(CFG_ENABLED_MASK, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'hFFFF);
        write_reg(CFG_STALE_TIMEOUT, 16'($urandom_range(0, 20)));
      end
      nsrc = (srccnt_reg > 7) ? 7 : srccnt_reg;
      if ($urandom_range(0, 4) == 0) begin
        send_noise();
        sent++;
      end else begin
        send_beam(nsrc, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000),
                  $urandom_range(0, 2) == 0);
        sent += nsrc;
      end
      if ($urandom_range(0, 15) == 0) wall_now = wall_now + $urandom_range(10, 40);
    end
  endtask

  // The receiver holds off while the sender keeps offering matching beams.
  task automatic test_backpressure();
    int k;
    write_reg(CFG_SOURCE_COUNT, 16'd7);
    write_reg(CFG_ENABLED_MASK, 16'h007F);
    hold_off = 1'b1;
    for (k = 0; k < 3; k++) send_beam(7, 32'd1000, 1'b0);
    hold_off = 1'b0;
  endtask

  // Receiver stall: random gaps plus one long counted hold when asked.
  initial begin
    int run;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        out_stall = 1'b0;
        while (hold_off) @(negedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        out_stall = 1'b1;
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        repeat (run - 1) @(negedge clk);
      end else if ($urandom_range(0, 1) == 0) begin
        out_stall = 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: %p", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.event_kind !== want.event_kind ||
            out_data.member_source !== want.member_source ||
            out_data.member_tag !== want.member_tag ||
            out_data.matches_so_far !== want.matches_so_far ||
            out_data.last_of_set !== want.last_of_set) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
        end
      end
    end
  end

  // Run limit.
  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[multi_source_time_matcher] ERROR");
    $finish;
  end

  initial begin
    st_count = 0;
    tolerance = TOL_RESET;
    last_seconds = 0;
    last_known = 1'b0;
    match_total = 0;
    mask_reg = ENABLED_RESET;
    srccnt_reg = SRCCNT_RESET;
    timeout_reg = TIMEOUT_RESET;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_full_store();
    test_directed();
    test_random(90);
    test_backpressure();
    test_random(90);

    wait_idle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[multi_source_time_matcher] OK");
    end else begin
      $display("[multi_source_time_matcher] ERROR");
    end
    $finish;
  end

endmodule

@@ multi_source_time_matcher.f @@
+incdir+design
design/mstm_pkg.sv
design/mstm_ram.sv
design/mstm_datapath.sv
design/mstm_ctrl.sv
design/multi_source_time_matcher.sv
verif/multi_source_time_matcher_test.sv
